FILE: hdl/rdb_pkg.sv
`timescale 1ns / 1ps

package rdb_pkg;

	// Defaults for the top-level parameters
	localparam int unsigned MAX_BLOCK_DEF   = 8192;
	localparam int unsigned LOG_ENTRIES_DEF = 64;

	// Datapath widths
	localparam int unsigned SAMPLE_W = 16;
	localparam int unsigned SQ_W     = 31;  // square of a Q1.15 sample, max 2^30
	localparam int unsigned ADD_W    = 32;  // sum of two squares
	localparam int unsigned SUM_W    = 45;
	localparam int unsigned CNT_W    = 14;
	localparam int unsigned CNT_MAX  = 16383;
	localparam int unsigned LOG_W    = 22;  // log2 in Q6.16
	localparam int unsigned L_W      = 24;  // signed log2 of mean power
	localparam int unsigned DBP_W    = 43;  // L times dB constant
	localparam int unsigned DB_W     = 15;
	localparam int unsigned LVL_W    = 16;
	localparam int unsigned SMOOTH_W = 24;
	localparam int unsigned COEFF_W  = 16;

	// Configuration port
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MUTE          = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SMOOTH_COEFF  = 2'd2;

	localparam logic [1:0]         CHAN_RESET  = 2'd2;
	localparam logic [COEFF_W-1:0] COEFF_RESET = 16'd58982;

	// dB arithmetic
	localparam logic signed [DB_W-1:0] DB_FLOOR      = -15'sd15360;
	localparam logic [13:0]            DB_SPAN       = 14'd15360;
	localparam logic signed [18:0]     DB_PER_LOG2   = 19'sd197283;  // 10*log10(2), Q.16
	localparam logic signed [L_W-1:0]  L_OFFSET_MONO = 24'sd1966080; // 30.0 in Q.16
	localparam logic signed [L_W-1:0]  L_OFFSET_STEREO = 24'sd2031616; // 31.0 in Q.16
	localparam logic [20:0]            DIV15_MUL     = 21'd1118481;  // floor(2^24/15)

	// Accumulator stage to finisher
	typedef struct packed {
		logic             frame;  // a frame leaves the merge stage
		logic             last;   // ... and it closes a block
		logic [SUM_W-1:0] sum;    // block totals including this frame
		logic [CNT_W-1:0] count;
	} blk_snap_t;

	// log2(1 + f) fraction bits by repeated squaring, x0 in Q2.30
	function automatic logic [15:0] log_frac(input logic [63:0] x0);
		logic [63:0] x;
		logic [15:0] v;
		x = x0;
		v = '0;
		for (int k = 0; k < 16; k++) begin
			x = (x * x) >> 30;
			v = {v[14:0], 1'b0};
			if (x >= (64'd1 << 31)) begin
				v[0] = 1'b1;
				x = x >> 1;
			end
		end
		return v;
	endfunction

endpackage

FILE: hdl/rdb_lane.sv
`timescale 1ns / 1ps

module rdb_lane
	import rdb_pkg::*;
(
	input  logic                       clk,
	input  logic                       en,
	input  logic signed [SAMPLE_W-1:0] sample,
	output logic        [SQ_W-1:0]     sq_s1
);

	logic signed [2*SAMPLE_W-1:0] sq;

	assign sq = sample * sample;

	always_ff @(posedge clk) begin
		if (en) begin
			sq_s1 <= sq[SQ_W-1:0];
		end
	end

endmodule

FILE: hdl/rdb_accum.sv
`timescale 1ns / 1ps

module rdb_accum
	import rdb_pkg::*;
#(
	parameter int unsigned MAX_BLOCK = MAX_BLOCK_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            fire,
	input  logic            last_of_block,
	input  logic            mute,
	input  logic            stereo,
	input  logic [SQ_W-1:0] sq_l_s1,
	input  logic [SQ_W-1:0] sq_r_s1,
	output blk_snap_t       snap
);

	localparam int unsigned CAP_INT = (MAX_BLOCK < CNT_MAX) ? MAX_BLOCK : CNT_MAX;
	localparam logic [CNT_W-1:0] CAP = CNT_W'(CAP_INT);

	logic             valid_s1;
	logic             last_s1;
	logic [SUM_W-1:0] sum_q;
	logic [CNT_W-1:0] count_q;

	logic             acc_en;
	logic [ADD_W-1:0] add;
	logic [SUM_W:0]   tot;
	logic [SUM_W-1:0] sum_nx;
	logic [CNT_W-1:0] cnt_nx;

	assign acc_en = valid_s1 && !mute && (count_q < CAP);
	assign add    = ADD_W'(sq_l_s1) + (stereo ? ADD_W'(sq_r_s1) : '0);
	assign tot    = (SUM_W+1)'(sum_q) + (SUM_W+1)'(add);
	assign sum_nx = !acc_en ? sum_q : (tot[SUM_W] ? '1 : tot[SUM_W-1:0]);
	assign cnt_nx = acc_en ? count_q + 1'b1 : count_q;

	assign snap.frame = valid_s1;
	assign snap.last  = valid_s1 && last_s1;
	assign snap.sum   = sum_nx;
	assign snap.count = cnt_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			last_s1  <= 1'b0;
			sum_q    <= '0;
			count_q  <= '0;
		end else begin
			valid_s1 <= fire;
			last_s1  <= fire && last_of_block;
			if (valid_s1 && last_s1) begin
				sum_q   <= '0;
				count_q <= '0;
			end else begin
				sum_q   <= sum_nx;
				count_q <= cnt_nx;
			end
		end
	end

endmodule

FILE: hdl/rdb_log2.sv
`timescale 1ns / 1ps

module rdb_log2
	import rdb_pkg::*;
#(
	parameter int unsigned LOG_TABLE_ENTRIES = LOG_ENTRIES_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [SUM_W-1:0] x,
	output logic             done,
	output logic [LOG_W-1:0] result
);

	localparam int unsigned IW = $clog2(LOG_TABLE_ENTRIES);

	typedef enum logic [3:0] {
		LG_IDLE = 4'b0001,
		LG_NORM = 4'b0010,
		LG_IDX  = 4'b0100,
		LG_LOOK = 4'b1000
	} lg_state_t;

	lg_state_t        state_q;
	logic [SUM_W-1:0] x_q;
	logic [5:0]       shift_q;
	logic [5:0]       p_q;
	logic [IW-1:0]    idx_q;
	logic             done_q;
	logic [LOG_W-1:0] result_q;

	logic [15:0]      tbl [LOG_TABLE_ENTRIES];
	logic [IW+31:0]   idx_prod;

	// log2(1 + i/N) fractions, fixed at elaboration
	for (genvar g = 0; g < LOG_TABLE_ENTRIES; g++) begin : g_tbl
		localparam logic [63:0] X0 = (64'd1 << 30)
			+ ((64'(g) << 30) / 64'(LOG_TABLE_ENTRIES));
		assign tbl[g] = log_frac(X0);
	end

	// 31 bits below the leading one, scaled to a table index
	assign idx_prod = (IW+32)'(x_q[SUM_W-2:SUM_W-32]) * (IW+32)'(LOG_TABLE_ENTRIES);

	assign done   = done_q;
	assign result = result_q;

	always_ff @(posedge clk) begin
		unique case (state_q)
			LG_IDLE: begin
				if (start) begin
					x_q     <= x;
					shift_q <= '0;
				end
			end
			LG_NORM: begin
				if (!(x_q[SUM_W-1] || x_q == '0)) begin
					if (x_q[SUM_W-1 -: 8] == '0) begin
						x_q     <= x_q << 8;
						shift_q <= shift_q + 6'd8;
					end else if (x_q[SUM_W-1 -: 4] == '0) begin
						x_q     <= x_q << 4;
						shift_q <= shift_q + 6'd4;
					end else begin
						x_q     <= x_q << 1;
						shift_q <= shift_q + 6'd1;
					end
				end
			end
			LG_IDX: begin
				idx_q <= idx_prod[IW+30:31];
				p_q   <= 6'(SUM_W - 1) - shift_q;
			end
			LG_LOOK: begin
				result_q <= {p_q, 16'b0} + LOG_W'(tbl[idx_q]);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= LG_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				LG_IDLE: if (start) state_q <= LG_NORM;
				LG_NORM: if (x_q[SUM_W-1] || x_q == '0) state_q <= LG_IDX;
				LG_IDX:  state_q <= LG_LOOK;
				LG_LOOK: begin
					done_q  <= 1'b1;
					state_q <= LG_IDLE;
				end
				default: state_q <= LG_IDLE;
			endcase
		end
	end

endmodule

FILE: hdl/rdb_finish.sv
`timescale 1ns / 1ps

module rdb_finish
	import rdb_pkg::*;
#(
	parameter int unsigned LOG_TABLE_ENTRIES = LOG_ENTRIES_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  blk_snap_t               snap,
	input  logic                    mute,
	input  logic                    stereo,
	input  logic [COEFF_W-1:0]      coeff,
	output logic                    busy,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [LVL_W-1:0]        level,
	output logic signed [DB_W-1:0]  level_db
);

	typedef enum logic [9:0] {
		FS_IDLE  = 10'b0000000001,
		FS_LOGS  = 10'b0000000010,
		FS_LOGC  = 10'b0000000100,
		FS_DBMUL = 10'b0000001000,
		FS_DB    = 10'b0000010000,
		FS_DIV   = 10'b0000100000,
		FS_FIX   = 10'b0001000000,
		FS_SMA   = 10'b0010000000,
		FS_SMB   = 10'b0100000000,
		FS_OUT   = 10'b1000000000
	} fin_state_t;

	fin_state_t              state_q;
	logic                    start_q;
	logic                    mute_blk_q;
	logic [SUM_W-1:0]        sum_q;
	logic [CNT_W-1:0]        cnt_q;
	logic [LOG_W-1:0]        ls_q;
	logic signed [L_W-1:0]   l_q;
	logic signed [DBP_W-1:0] dbp_q;
	logic signed [DB_W-1:0]  db_q;
	logic [19:0]             n_q;
	logic [16:0]             q0_q;
	logic [LVL_W-1:0]        norm_q;
	logic [39:0]             pa_q;
	logic [40:0]             pb_q;
	logic [SMOOTH_W-1:0]     smooth_q;
	logic                    out_valid_q;
	logic [LVL_W-1:0]        level_q;
	logic signed [DB_W-1:0]  level_db_q;

	logic                    log_done;
	logic [LOG_W-1:0]        log_res;
	logic [SUM_W-1:0]        log_x;
	logic signed [L_W-1:0]   l_nx;
	logic signed [DBP_W-1:0] dbp_rnd;
	logic signed [18:0]      db_full;
	logic [13:0]             db_off;
	logic [19:0]             n_nx;
	logic [40:0]             q_prod;
	logic [20:0]             q_x15;
	logic [20:0]             rem;
	logic [16:0]             q_fix;
	logic [41:0]             blend;
	logic                    out_free;

	rdb_log2 #(
		.LOG_TABLE_ENTRIES(LOG_TABLE_ENTRIES)
	) u_log2 (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start_q),
		.x     (log_x),
		.done  (log_done),
		.result(log_res)
	);

	assign log_x = (state_q == FS_LOGC) ? SUM_W'(cnt_q) : sum_q;

	// mean power in log2, less the Q30 scale of the squares and the channel count
	assign l_nx = $signed(L_W'(ls_q)) - $signed(L_W'(log_res))
		- (stereo ? L_OFFSET_STEREO : L_OFFSET_MONO);

	assign dbp_rnd = dbp_q + $signed(DBP_W'(1) << 23);
	assign db_full = dbp_rnd[DBP_W-1:24];

	// (db + 60 dB) / 60 dB in Q0.16, divide by 15 via reciprocal
	assign db_off = 14'(db_q - DB_FLOOR);
	assign n_nx   = {db_off, 6'b0} + 20'd7;
	assign q_prod = 41'(n_nx) * 41'(DIV15_MUL);
	assign q_x15  = (21'(q0_q) << 4) - 21'(q0_q);
	assign rem    = 21'(n_q) - q_x15;
	assign q_fix  = (rem >= 21'd15) ? q0_q + 1'b1 : q0_q;

	assign blend    = 42'(pa_q) + 42'(pb_q) + 42'd32768;
	assign out_free = !out_valid_q || !out_stall;

	assign busy      = (state_q != FS_IDLE);
	assign out_valid = out_valid_q;
	assign level     = level_q;
	assign level_db  = level_db_q;

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			FS_IDLE: begin
				if (snap.last) begin
					sum_q <= snap.sum;
					cnt_q <= snap.count;
					if (mute || snap.sum == '0) begin
						db_q <= DB_FLOOR;
					end
				end
			end
			FS_LOGS: if (log_done) ls_q <= log_res;
			FS_LOGC: if (log_done) l_q <= l_nx;
			FS_DBMUL: dbp_q <= DBP_W'(l_q) * DBP_W'(DB_PER_LOG2);
			FS_DB: begin
				if (db_full < 19'(DB_FLOOR)) begin
					db_q <= DB_FLOOR;
				end else if (db_full > 19'sd0) begin
					db_q <= '0;
				end else begin
					db_q <= db_full[DB_W-1:0];
				end
			end
			FS_DIV: begin
				n_q  <= n_nx;
				q0_q <= q_prod[40:24];
			end
			FS_FIX: norm_q <= q_fix[16] ? '1 : q_fix[LVL_W-1:0];
			FS_SMA: pa_q <= 40'(smooth_q) * 40'(coeff);
			FS_SMB: pb_q <= 41'({norm_q, 8'b0}) * 41'(17'h10000 - 17'(coeff));
			FS_OUT: begin
				if (out_free) begin
					level_db_q <= db_q;
					level_q    <= mute_blk_q ? '0 : blend[39:24];
				end
			end
			default: ;
		endcase
	end

	// control and smoothed level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= FS_IDLE;
			start_q     <= 1'b0;
			mute_blk_q  <= 1'b0;
			smooth_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			start_q <= 1'b0;
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (snap.frame && mute) begin
				smooth_q <= '0;
			end
			unique case (state_q)
				FS_IDLE: begin
					if (snap.last) begin
						mute_blk_q <= mute;
						if (mute) begin
							state_q <= FS_OUT;
						end else if (snap.sum == '0) begin
							state_q <= FS_DIV;
						end else begin
							state_q <= FS_LOGS;
							start_q <= 1'b1;
						end
					end
				end
				FS_LOGS: begin
					if (log_done) begin
						state_q <= FS_LOGC;
						start_q <= 1'b1;
					end
				end
				FS_LOGC:  if (log_done) state_q <= FS_DBMUL;
				FS_DBMUL: state_q <= FS_DB;
				FS_DB:    state_q <= FS_DIV;
				FS_DIV:   state_q <= FS_FIX;
				FS_FIX:   state_q <= FS_SMA;
				FS_SMA:   state_q <= FS_SMB;
				FS_SMB:   state_q <= FS_OUT;
				FS_OUT: begin
					if (out_free) begin
						smooth_q    <= mute_blk_q ? '0 : blend[39:16];
						out_valid_q <= 1'b1;
						state_q     <= FS_IDLE;
					end
				end
				default: state_q <= FS_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	// a block closes only when the finisher is free
	assert property (@(posedge clk) disable iff (!arst_n)
		snap.last |-> state_q == FS_IDLE)
		else $error("block closed while finisher busy");

	// no frame may reach the accumulators while a block is being finished
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q != FS_IDLE |-> !snap.frame)
		else $error("frame accumulated during finish");

	// reported level stays within the clamp range
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (level_db_q <= 15'sd0 && level_db_q >= DB_FLOOR))
		else $error("level_db outside clamp range");

	// a muted block reports the floor
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == FS_OUT && mute_blk_q && out_free) |=> (level_q == '0 && level_db_q == DB_FLOOR))
		else $error("muted block not at floor");
`endif

endmodule

FILE: hdl/rms_db_level_meter.sv
`timescale 1ns / 1ps

// Block RMS level meter. Each input transaction is one stereo frame of signed
// Q1.15 samples; frames inside a block are taken one per clock. The frame that
// carries last_of_block closes the block: the mean power over frames and
// channels is taken as 10*log10 through a log2 table, clamped to -60..0 dB
// (level_db, Q8.8), mapped to 0..1 and blended into a one-pole smoothed level
// (level, Q0.16), giving one output transaction. For a block with power the
// shared log2 unit runs twice with a shift-by-8/4/1 leading-one search,
// first on the block sum and then on the frame count; the dB multiply,
// the divide-by-15 normalization with its fix-up step and the two
// smoothing multiplies follow in registered states of their own. A
// silent block skips the log2 unit and a muted one goes straight to the
// output register. in_stall is high from the cycle after
// the closing frame until the report is registered, and longer while
// out_stall holds the previous report. Write configuration only while idle:
// cfg_index 0 = channel_count (1 left only, 2 both; 0 acts as 1, 3 as 2),
// 1 = mute, 2 = smoothing_coeff (weight of the previous level, Q0.16). While
// muted frames are not accumulated, the smoothed level is held at zero and a
// closed block reports level 0 at -60 dB. Sum and frame count saturate; frames
// past min(MAX_BLOCK, 16383) in a block are dropped.

module rms_db_level_meter
	import rdb_pkg::*;
#(
	parameter int unsigned MAX_BLOCK         = MAX_BLOCK_DEF,
	parameter int unsigned LOG_TABLE_ENTRIES = LOG_ENTRIES_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,

	// configuration writes
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [CFG_IDX_W-1:0]       cfg_index,
	input  logic [CFG_DATA_W-1:0]      cfg_data,

	// frame input
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic signed [SAMPLE_W-1:0] left_sample,
	input  logic signed [SAMPLE_W-1:0] right_sample,
	input  logic                       last_of_block,

	// level output
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [LVL_W-1:0]           level,
	output logic signed [DB_W-1:0]     level_db
);

	logic [1:0]         chan_q;
	logic               mute_q;
	logic [COEFF_W-1:0] coeff_q;

	logic               fire;
	logic               stereo;
	logic               fin_busy;
	logic [SQ_W-1:0]    sq_l_s1;
	logic [SQ_W-1:0]    sq_r_s1;
	blk_snap_t          snap;

	// configuration registers; writes always accepted
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chan_q  <= CHAN_RESET;
			mute_q  <= 1'b0;
			coeff_q <= COEFF_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_CHANNEL_COUNT: chan_q  <= cfg_data[1:0];
				CFG_MUTE:          mute_q  <= cfg_data[0];
				CFG_SMOOTH_COEFF:  coeff_q <= cfg_data[COEFF_W-1:0];
				default: ;
			endcase
		end
	end

	// 2 or 3 mean both channels
	assign stereo = chan_q[1];

	// hold off while a closing frame is in the merge stage or a block is being finished
	assign in_stall = fin_busy || snap.last;
	assign fire     = in_valid && !in_stall;

	// one squaring lane per channel
	rdb_lane u_lane_l (
		.clk   (clk),
		.en    (fire),
		.sample(left_sample),
		.sq_s1 (sq_l_s1)
	);

	rdb_lane u_lane_r (
		.clk   (clk),
		.en    (fire),
		.sample(right_sample),
		.sq_s1 (sq_r_s1)
	);

	// merge lanes into the block sum and frame count
	rdb_accum #(
		.MAX_BLOCK(MAX_BLOCK)
	) u_accum (
		.clk          (clk),
		.arst_n       (arst_n),
		.fire         (fire),
		.last_of_block(last_of_block),
		.mute         (mute_q),
		.stereo       (stereo),
		.sq_l_s1      (sq_l_s1),
		.sq_r_s1      (sq_r_s1),
		.snap         (snap)
	);

	// log-domain dB, normalization, smoothing and output register
	rdb_finish #(
		.LOG_TABLE_ENTRIES(LOG_TABLE_ENTRIES)
	) u_finish (
		.clk      (clk),
		.arst_n   (arst_n),
		.snap     (snap),
		.mute     (mute_q),
		.stereo   (stereo),
		.coeff    (coeff_q),
		.busy     (fin_busy),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.level    (level),
		.level_db (level_db)
	);

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps

// Block-level check of rms_db_level_meter.
// Frames go in through the valid/stall frame port, level reports come out of
// the valid/stall report port, registers go through the cfg valid/ready port.
// Every accepted frame is fed to a local model of the meter. Each block-closing
// frame queues one expected report. Each accepted report is checked against the
// oldest queued one.

module tb;
	import rdb_pkg::*;

	typedef logic signed [SAMPLE_W-1:0] sample_t;

	// one report transaction
	typedef struct packed {
		logic [LVL_W-1:0]       level;
		logic signed [DB_W-1:0] level_db;
	} level_rslt_t;

	typedef enum logic {ROW_FRAME, ROW_CFG} row_kind_t;

	// directed stimulus row: a frame, or a register write done while idle
	typedef struct {
		row_kind_t             kind;
		logic [CFG_IDX_W-1:0]  idx;
		logic [CFG_DATA_W-1:0] data;
		sample_t               left;
		sample_t               right;
		logic                  last;
		logic                  pinned;  // report is known by hand, use want
		level_rslt_t           want;
	} stim_row_t;

	// frames past this count in one block are dropped
	localparam int unsigned FRAME_CAP =
		(MAX_BLOCK_DEF < CNT_MAX) ? MAX_BLOCK_DEF : CNT_MAX;
	localparam logic [SUM_W-1:0]     SUM_CEIL   = '1;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;  // no register behind it
	localparam int CLOSE_LATENCY = 64;  // time allowed for a block close to finish
	localparam int RAND_PHASES   = 12;
	localparam int PHASE_FRAMES  = 85;
	localparam level_rslt_t FLOOR_RSLT = '{level: '0, level_db: DB_FLOOR};

	// Clock and reset
	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// DUT ports
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	logic    in_valid = 1'b0;
	logic    in_stall;
	sample_t left_sample   = '0;
	sample_t right_sample  = '0;
	logic    last_of_block = 1'b0;

	logic                   out_valid;
	logic                   out_stall = 1'b0;
	logic [LVL_W-1:0]       level;
	logic signed [DB_W-1:0] level_db;

	rms_db_level_meter u_top (.*);

	// Local meter model state: register copies, block accumulators and the
	// smoothed level in Q0.24.
	logic [15:0]         log2_frac_lut [LOG_ENTRIES_DEF];
	logic [1:0]          meter_chans  = CHAN_RESET;
	logic                meter_mute   = 1'b0;
	logic [COEFF_W-1:0]  meter_coeff  = COEFF_RESET;
	logic [SUM_W-1:0]    blk_power    = '0;
	logic [CNT_W-1:0]    blk_frames   = '0;
	logic [SMOOTH_W-1:0] smooth_level = '0;

	level_rslt_t pending_levels [$];  // reports still owed by the DUT
	int          mismatch_count = 0;
	bit          no_idle        = 1'b0;  // both sides run back to back
	int          stall_left     = 0;

	// log2(1 + i/N) fraction, 16 squaring rounds in Q2.30
	initial begin
		logic [63:0] x;
		logic [15:0] v;
		for (int i = 0; i < LOG_ENTRIES_DEF; i++) begin
			x = (64'd1 << 30) + ((64'(i) << 30) / LOG_ENTRIES_DEF);
			v = '0;
			for (int k = 0; k < 16; k++) begin
				x = (x * x) >> 30;
				v = v << 1;
				if (x >= (64'd1 << 31)) begin
					v[0] = 1'b1;
					x = x >> 1;
				end
			end
			log2_frac_lut[i] = v;
		end
	end

	// log2 of x > 0 in Q.16: leading-one position plus a table fraction
	function automatic longint log2_q16(input logic [63:0] x);
		int          lead;
		logic [63:0] mant;
		logic [63:0] idx;
		lead = 0;
		for (int b = 0; b < 64; b++)
			if (x[b]) lead = b;
		mant = (lead <= 31) ? (x << (31 - lead)) : (x >> (lead - 31));
		mant = mant & 64'h7FFF_FFFF;
		idx  = (mant * LOG_ENTRIES_DEF) >> 31;
		if (idx >= LOG_ENTRIES_DEF)
			idx = LOG_ENTRIES_DEF - 1;
		return longint'(lead) * 65536 + longint'(log2_frac_lut[idx]);
	endfunction

	// Takes one accepted frame. Returns 1 with the report when the frame
	// closes a block.
	function automatic bit meter_take_frame(input sample_t l, input sample_t r,
			input logic last, output level_rslt_t rpt);
		logic [63:0]     sum;
		longint          lg;
		longint          prod;
		longint          db;
		longint          norm;
		longint unsigned blend;
		rpt = FLOOR_RSLT;
		// muted: nothing is summed and the smoothed level stays cleared
		if (meter_mute) begin
			smooth_level = '0;
		end else if (blk_frames < FRAME_CAP) begin
			sum = 64'(blk_power) + 64'(longint'(l) * longint'(l));
			// channel count 2 or 3 takes both sides, 0 or 1 left only
			if (meter_chans[1])
				sum += 64'(longint'(r) * longint'(r));
			blk_power  = (sum > 64'(SUM_CEIL)) ? SUM_CEIL : sum[SUM_W-1:0];
			blk_frames = blk_frames + 1'b1;
		end
		if (!last)
			return 1'b0;
		if (!meter_mute) begin
			// silent block sits at the floor, no log taken
			if (blk_power == '0 || blk_frames == '0) begin
				db = longint'(DB_FLOOR);
			end else begin
				// mean power in the log domain: sum over frames and channels,
				// then undo the 2^-30 scale of the squares
				lg = log2_q16(64'(blk_power)) - log2_q16(64'(blk_frames))
					- longint'(meter_chans[1] ? 31 : 30) * 65536;
				prod = lg * longint'(DB_PER_LOG2) + (longint'(1) << 23);
				db   = prod >>> 24;  // floor division
				if (db < longint'(DB_FLOOR))
					db = longint'(DB_FLOOR);
				if (db > 0)
					db = 0;
			end
			norm = ((db - longint'(DB_FLOOR)) * 65536 + 7680) / 15360;
			if (norm > 65535)
				norm = 65535;
			blend = longint'(smooth_level) * meter_coeff
				+ (longint'(norm) << 8) * (65536 - meter_coeff) + 32768;
			smooth_level   = SMOOTH_W'(blend >> 16);
			rpt.level      = smooth_level[SMOOTH_W-1:8];
			rpt.level_db   = DB_W'(db);
		end
		// accumulators clear after every closing frame
		blk_power  = '0;
		blk_frames = '0;
		return 1'b1;
	endfunction

	// Random gap length: mostly none or short, now and then a long one
	function automatic int pick_gap();
		int roll;
		if (no_idle)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 60)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		if (roll < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic sample_t rand_sample(input int shift);
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 3)
			return 16'sh8000;
		if (roll < 6)
			return 16'sh7FFF;
		if (roll < 8)
			return '0;
		return sample_t'($urandom) >>> shift;
	endfunction

	function automatic stim_row_t frame_row(input sample_t l, input sample_t r,
			input logic last, input logic pinned = 1'b0,
			input level_rslt_t want = FLOOR_RSLT);
		stim_row_t row;
		row = '{kind: ROW_FRAME, idx: '0, data: '0, left: l, right: r,
			last: last, pinned: pinned, want: want};
		return row;
	endfunction

	function automatic stim_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		stim_row_t row;
		row = '{kind: ROW_CFG, idx: idx, data: data, left: '0, right: '0,
			last: 1'b0, pinned: 1'b0, want: FLOOR_RSLT};
		return row;
	endfunction

	// Drop valid, let every owed report come out, then give the block time
	// to finish anything that produces no report.
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_levels.size() != 0)
			@(posedge clk);
		repeat (CLOSE_LATENCY) @(posedge clk);
	endtask

	// One register write transaction; the model copy follows the handshake.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_CHANNEL_COUNT: meter_chans = data[1:0];
			CFG_MUTE:          meter_mute  = data[0];
			CFG_SMOOTH_COEFF:  meter_coeff = data;
			default: ;
		endcase
	endtask

	// One frame transaction. Valid is only dropped when a gap is taken, so
	// back-to-back frames keep it high across the edge.
	task automatic push_frame(input sample_t l, input sample_t r, input logic last,
			input logic pinned = 1'b0, input level_rslt_t want = FLOOR_RSLT);
		int          gap;
		level_rslt_t rpt;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid      <= 1'b1;
		left_sample   <= l;
		right_sample  <= r;
		last_of_block <= last;
		do @(posedge clk); while (in_stall);
		if (meter_take_frame(l, r, last, rpt))
			pending_levels.insert(pending_levels.size(), pinned ? want : rpt);
	endtask

	// Report side: check each accepted report, then pick the next stall state.
	// Values are sampled at the edge, before this edge's updates land.
	always @(posedge clk) begin
		level_rslt_t want;
		if (out_valid && !out_stall) begin
			if (pending_levels.size() == 0) begin
				$error("level report with none pending: level=%0d level_db=%0d",
					level, level_db);
				mismatch_count++;
			end else begin
				want = pending_levels.pop_front();
				if (level !== want.level) begin
					$error("level: expected %0d, got %0d", want.level, level);
					mismatch_count++;
				end
				if (level_db !== want.level_db) begin
					$error("level_db: expected %0d, got %0d", want.level_db, level_db);
					mismatch_count++;
				end
			end
		end
		if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
			stall_left = pick_gap();
		end
	end

	// Main sequence
	initial begin
		stim_row_t          dir_rows [$];
		logic [COEFF_W-1:0] coeff;
		int                 sent;
		int                 blk_len;
		int                 shift;
		int                 roll;

		// Directed part. Rows marked pinned carry a report known by hand:
		// silent and muted blocks sit at the floor with a zero level.
		// Silent block straight out of reset
		dir_rows.insert(dir_rows.size(),
			frame_row(16'sh0000, 16'sh0000, 1'b1, 1'b1, FLOOR_RSLT));
		// Full scale negative, then positive extremes over two frames
		dir_rows.insert(dir_rows.size(), frame_row(16'sh8000, 16'sh8000, 1'b1));
		dir_rows.insert(dir_rows.size(), frame_row(16'sh7FFF, 16'sh7FFF, 1'b0));
		dir_rows.insert(dir_rows.size(), frame_row(16'sh7FFF, 16'sh8000, 1'b1));
		// Tiny power: clamps at -60 dB while the smoothed level decays
		dir_rows.insert(dir_rows.size(), frame_row(16'sh0001, -16'sh0001, 1'b0));
		dir_rows.insert(dir_rows.size(), frame_row(16'sh0000, 16'sh0000, 1'b1));
		// Mixed mid-level block
		dir_rows.insert(dir_rows.size(), frame_row(16'sh5A5A, -16'sh2001, 1'b0));
		dir_rows.insert(dir_rows.size(), frame_row(-16'sh0100, 16'sh7FFF, 1'b0));
		dir_rows.insert(dir_rows.size(), frame_row(16'sh00FF, 16'sh8000, 1'b1));
		// Mono: right side ignored, so a right-only block reads as silence
		dir_rows.insert(dir_rows.size(), cfg_row(CFG_CHANNEL_COUNT, 16'd1));
		dir_rows.insert(dir_rows.size(), frame_row(16'sh8000, 16'sh7FFF, 1'b1));
		dir_rows.insert(dir_rows.size(), frame_row(16'sh0000, 16'sh7FFF, 1'b1));
		// Channel count 0 acts as mono, 3 as stereo
		dir_rows.insert(dir_rows.size(), cfg_row(CFG_CHANNEL_COUNT, 16'd0));
		dir_rows.insert(dir_rows.size(), frame_row(16'sh3039, -16'sh0001, 1'b1));
		dir_rows.insert(dir_rows.size(), cfg_row(CFG_CHANNEL_COUNT, 16'd3));
		dir_rows.insert(dir_rows.size(), frame_row(-16'sh0001, 16'sh4000, 1'b1));
		// Smoothing extremes: no memory, then almost all memory
		dir_rows.insert(dir_rows.size(), cfg_row(CFG_SMOOTH_COEFF, 16'h0000));
		dir_rows.insert(dir_rows.size(), frame_row(16'sh7FFF, 16'sh7FFF, 1'b1));
		dir_rows.insert(dir_rows.size(), frame_row(16'sh0100, -16'sh0100, 1'b1));
		dir_rows.insert(dir_rows.size(), cfg_row(CFG_SMOOTH_COEFF, 16'hFFFF));
		dir_rows.insert(dir_rows.size(), frame_row(16'sh8000, 16'sh8000, 1'b1));
		// Muted: loud frames are dropped and the floor is reported
		dir_rows.insert(dir_rows.size(), cfg_row(CFG_MUTE, 16'd1));
		dir_rows.insert(dir_rows.size(), frame_row(16'sh7FFF, 16'sh7FFF, 1'b0));
		dir_rows.insert(dir_rows.size(),
			frame_row(16'sh8000, 16'sh8000, 1'b1, 1'b1, FLOOR_RSLT));
		// Unmuted: the smoothed level restarts from zero
		dir_rows.insert(dir_rows.size(), cfg_row(CFG_MUTE, 16'd0));
		dir_rows.insert(dir_rows.size(),
			frame_row(16'sh0000, 16'sh0000, 1'b1, 1'b1, FLOOR_RSLT));
		// Write to the unused index must change nothing; back to reset values
		dir_rows.insert(dir_rows.size(), cfg_row(CFG_UNUSED, 16'hFFFF));
		dir_rows.insert(dir_rows.size(), cfg_row(CFG_CHANNEL_COUNT, 16'd2));
		dir_rows.insert(dir_rows.size(), cfg_row(CFG_SMOOTH_COEFF, COEFF_RESET));
		dir_rows.insert(dir_rows.size(), frame_row(16'sh7FFF, 16'sh0000, 1'b0));
		dir_rows.insert(dir_rows.size(), frame_row(16'sh0000, 16'sh7FFF, 1'b1));

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[i]) begin
			if (dir_rows[i].kind == ROW_CFG) begin
				wait_idle();
				write_reg(dir_rows[i].idx, dir_rows[i].data);
			end else begin
				push_frame(dir_rows[i].left, dir_rows[i].right, dir_rows[i].last,
					dir_rows[i].pinned, dir_rows[i].want);
			end
		end

		// Random phases: fresh settings each phase (junk in the unused data
		// bits), whole blocks of random length and loudness inside.
		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			wait_idle();
			write_reg(CFG_CHANNEL_COUNT, {14'($urandom), 2'($urandom)});
			write_reg(CFG_MUTE, {15'($urandom), 1'(ph % 6 == 4)});
			case (ph % 4)
				0: coeff = '0;
				1: coeff = '1;
				2: coeff = COEFF_RESET;
				default: coeff = COEFF_W'($urandom);
			endcase
			write_reg(CFG_SMOOTH_COEFF, coeff);
			no_idle = (ph % 5 == 3);
			sent = 0;
			while (sent < PHASE_FRAMES) begin
				roll = $urandom_range(0, 99);
				if (roll < 70)
					blk_len = $urandom_range(1, 12);
				else if (roll < 95)
					blk_len = $urandom_range(13, 60);
				else
					blk_len = $urandom_range(61, 250);
				// per-block loudness spreads the dB result over its range
				shift = $urandom_range(0, 15);
				for (int f = 0; f < blk_len; f++)
					push_frame(rand_sample(shift), rand_sample(shift), f == blk_len - 1);
				sent += blk_len;
			end
		end
		no_idle = 1'b0;

		wait_idle();
		if (mismatch_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	// Hang guard
	initial begin
		#4_000_000;
		$display("Regression FAIL");
		$finish;
	end

endmodule

FILE: rms_db_level_meter.f
hdl/rdb_pkg.sv
hdl/rdb_lane.sv
hdl/rdb_accum.sv
hdl/rdb_log2.sv
hdl/rdb_finish.sv
hdl/rms_db_level_meter.sv
dv/tb.sv
